// ===== design/gsn_pkg.sv =====
package gsn_pkg;

    localparam int CoordW  = 24;   // vertex coordinate
    localparam int DiffW   = 25;   // edge vector component
    localparam int ProdW   = 50;   // one product of the shared multiplier
    localparam int CrossW  = 51;   // cross product component
    localparam int MagW    = 50;   // magnitude of a cross component
    localparam int NormW   = 24;   // normalized magnitude
    localparam int SumW    = 50;   // sum of squares
    localparam int RootW   = 64;   // root iteration width
    localparam int RootOutW = 32;  // final root
    localparam int NumW    = 48;   // divider remainder
    localparam int QW      = 15;   // quotient magnitude
    localparam int CompW   = 16;   // Q1.14 output component
    localparam int CellW   = 12;   // cell index outputs
    localparam int CfgW    = 13;   // column count register
    localparam int StepW   = 5;
    localparam int QDepth  = 2;
    localparam int QPtrW   = 1;
    localparam int QCntW   = 2;

    localparam int MulSteps  = 6;
    localparam int SqrSteps  = 3;
    localparam int RootSteps = 32;
    localparam int DivSteps  = 15;
    localparam int SqrShift  = 12;  // root taken of sum * 4096
    localparam int NumShift  = 21;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        t_vec             cur;
        t_vec             vc;
        t_vec             vu;
        logic [CellW-1:0] row;
        logic [CellW-1:0] col;
    } t_job;

    typedef struct packed {
        logic signed [CompW-1:0] nx;
        logic signed [CompW-1:0] ny;
        logic signed [CompW-1:0] nz;
        logic [CellW-1:0]        row;
        logic [CellW-1:0]        col;
        logic                    degen;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MAG,
        ST_NORM,
        ST_SQR,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

// ===== design/gsn_if.sv =====
interface gsn_vertex_if;
    logic                           valid;
    logic                           ready;
    logic signed [gsn_pkg::CoordW-1:0] vertex_x;
    logic signed [gsn_pkg::CoordW-1:0] vertex_y;
    logic signed [gsn_pkg::CoordW-1:0] vertex_z;
    logic                           grid_start;

    modport source (output valid, vertex_x, vertex_y, vertex_z, grid_start, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, grid_start, output ready);
endinterface

interface gsn_normal_if;
    logic                              valid;
    logic                              ready;
    logic signed [gsn_pkg::CompW-1:0]  normal_x;
    logic signed [gsn_pkg::CompW-1:0]  normal_y;
    logic signed [gsn_pkg::CompW-1:0]  normal_z;
    logic [gsn_pkg::CellW-1:0]         cell_row;
    logic [gsn_pkg::CellW-1:0]         cell_col;
    logic                              degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, cell_row, cell_col,
                    degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, cell_row, cell_col,
                    degenerate, output ready);
endinterface

// ===== design/gsn_front.sv =====
module gsn_front #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gsn_pkg::CfgW-1:0]   i_grid_columns,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  gsn_pkg::t_vec              i_vertex,
    input  logic                       i_grid_start,
    output logic                       o_job_valid,
    input  logic                       i_job_ready,
    output gsn_pkg::t_job              o_job
);
    import gsn_pkg::*;

    localparam int AW   = $clog2(MAX_COLUMNS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CNTW = AW + 1;
    localparam int CMPW = (CNTW > CfgW) ? CNTW : CfgW;
    localparam int XW   = (AW > CellW) ? AW : CellW;
    localparam int YW   = (RW > CellW) ? RW : CellW;

    t_vec            r_mem [MAX_COLUMNS];
    t_vec            r_rd_c;
    t_vec            r_rd_u;
    t_vec            r_cur;
    logic [CellW-1:0] r_cell_row;
    logic [CellW-1:0] r_cell_col;
    logic [AW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            r_s1_valid;
    logic            r_s1_prod;

    logic [AW-1:0]   col_now;
    logic [AW-1:0]   col_up;
    logic [RW-1:0]   row_now;
    logic [RW-1:0]   row_m1;
    logic [CMPW-1:0] cfg_ext;
    logic [CMPW-1:0] cols;
    logic [CMPW-1:0] col_next;
    logic [XW-1:0]   col_ext;
    logic [YW-1:0]   row_ext;
    logic            last;
    logic            produce;
    logic            accept;

    assign col_now  = i_grid_start ? '0 : r_col;
    assign row_now  = i_grid_start ? '0 : r_row;
    assign col_up   = col_now + AW'(1);
    assign row_m1   = row_now - RW'(1);
    assign col_ext  = XW'(col_now);
    assign row_ext  = YW'(row_m1);
    assign cfg_ext  = CMPW'(i_grid_columns);

    // clamp column count to [2, MAX_COLUMNS]
    always_comb begin
        if (cfg_ext < CMPW'(2)) begin
            cols = CMPW'(2);
        end else if (cfg_ext > CMPW'(MAX_COLUMNS)) begin
            cols = CMPW'(MAX_COLUMNS);
        end else begin
            cols = cfg_ext;
        end
    end

    assign col_next = CMPW'(col_now) + CMPW'(1);
    assign last     = (col_next >= cols);
    assign produce  = (row_now != '0) && !last;

    assign o_ready     = !r_s1_valid || !r_s1_prod || i_job_ready;
    assign accept      = i_valid && o_ready;
    assign o_job_valid = r_s1_valid && r_s1_prod;
    assign o_job       = '{cur: r_cur, vc: r_rd_c, vu: r_rd_u, row: r_cell_row, col: r_cell_col};

    // line buffer: reads see the previous row before this beat overwrites it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[col_now] <= i_vertex;
            r_rd_c         <= r_mem[col_now];
            r_rd_u         <= r_mem[col_up];
            r_cur          <= i_vertex;
            r_cell_row     <= row_ext[CellW-1:0];
            r_cell_col     <= col_ext[CellW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_prod  <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_s1_prod  <= produce;
            if (last) begin
                r_col <= '0;
                r_row <= (row_now == RW'(MAX_ROWS - 1)) ? '0 : row_now + RW'(1);
            end else begin
                r_col <= col_now + AW'(1);
                r_row <= row_now;
            end
        end else if (!r_s1_prod || i_job_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

endmodule

// ===== design/gsn_queue.sv =====
module gsn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  gsn_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output gsn_pkg::t_job o_pop_job
);
    import gsn_pkg::*;

    t_job             r_entry [QDepth];
    logic [QPtrW-1:0] r_wr;
    logic [QPtrW-1:0] r_rd;
    logic [QCntW-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != QCntW'(QDepth));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_job    = r_entry[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPtrW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPtrW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCntW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCntW'(1);
            end
        end
    end

endmodule

// ===== design/gsn_back.sv =====
module gsn_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  gsn_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output gsn_pkg::t_result o_result
);
    import gsn_pkg::*;

    t_back_state               r_state;
    t_back_state               n_state;
    logic [StepW-1:0]          r_step;
    logic signed [DiffW-1:0]   r_a [3];
    logic signed [DiffW-1:0]   r_b [3];
    logic signed [ProdW-1:0]   r_prod;
    logic signed [CrossW-1:0]  r_c [3];
    logic [MagW-1:0]           r_s [3];
    logic [MagW-1:0]           r_m;
    logic [SumW-1:0]           r_sum;
    logic [RootW-1:0]          r_x;
    logic [RootW-1:0]          r_res;
    logic [RootW-1:0]          r_bit;
    logic [NumW-1:0]           r_rem [3];
    logic [NumW-1:0]           r_den;
    logic [QW-1:0]             r_q [3];
    logic [CellW-1:0]          r_row;
    logic [CellW-1:0]          r_col;
    t_result                   r_out;
    logic                      r_out_valid;

    logic signed [DiffW-1:0]   mul_a;
    logic signed [DiffW-1:0]   mul_b;
    logic signed [ProdW-1:0]   mul_p;
    logic [MagW-1:0]           mag [3];
    logic [MagW-1:0]           mag_max;
    logic [SumW-1:0]           sum_fin;
    logic [RootW-1:0]          trial;
    logic [RootOutW-1:0]       root;
    logic signed [CompW-1:0]   comp [3];
    logic                      out_free;
    logic                      degen;

    assign out_free    = !r_out_valid || i_ready;
    assign o_job_ready = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;
    assign mul_p       = mul_a * mul_b;
    assign sum_fin     = r_sum + SumW'(r_prod);
    assign trial       = r_res + r_bit;
    assign root        = r_res[RootOutW-1:0];
    assign degen       = (r_m == '0);

    // shared multiplier: six cross terms, then three squares
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_MUL) begin
            case (r_step)
                StepW'(0): begin mul_a = r_a[1]; mul_b = r_b[2]; end
                StepW'(1): begin mul_a = r_a[2]; mul_b = r_b[1]; end
                StepW'(2): begin mul_a = r_a[2]; mul_b = r_b[0]; end
                StepW'(3): begin mul_a = r_a[0]; mul_b = r_b[2]; end
                StepW'(4): begin mul_a = r_a[0]; mul_b = r_b[1]; end
                StepW'(5): begin mul_a = r_a[1]; mul_b = r_b[0]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == ST_SQR) begin
            case (r_step)
                StepW'(0): begin
                    mul_a = $signed({1'b0, r_s[0][NormW-1:0]});
                    mul_b = $signed({1'b0, r_s[0][NormW-1:0]});
                end
                StepW'(1): begin
                    mul_a = $signed({1'b0, r_s[1][NormW-1:0]});
                    mul_b = $signed({1'b0, r_s[1][NormW-1:0]});
                end
                StepW'(2): begin
                    mul_a = $signed({1'b0, r_s[2][NormW-1:0]});
                    mul_b = $signed({1'b0, r_s[2][NormW-1:0]});
                end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = r_c[i][CrossW-1] ? MagW'(-r_c[i]) : MagW'(r_c[i]);
        end
        mag_max = mag[0];
        if (mag[1] > mag_max) begin
            mag_max = mag[1];
        end
        if (mag[2] > mag_max) begin
            mag_max = mag[2];
        end
    end

    // sign flip: a positive cross component gives a negative normal component
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (degen) begin
                comp[i] = '0;
            end else if (!r_c[i][CrossW-1] && (r_c[i] != '0)) begin
                comp[i] = -$signed(CompW'(r_q[i]));
            end else begin
                comp[i] = $signed(CompW'(r_q[i]));
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_step == StepW'(MulSteps)) n_state = ST_MAG;
            end
            ST_MAG:  n_state = ST_NORM;
            ST_NORM: begin
                if (degen) begin
                    n_state = ST_DONE;
                end else if ((r_m[MagW-1:NormW] == '0) && r_m[NormW-1]) begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                if (r_step == StepW'(SqrSteps)) n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (r_step == StepW'(RootSteps - 1)) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == StepW'(DivSteps)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? '0 : r_step + StepW'(1);
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_a[0] <= DiffW'(i_job.cur.x) - DiffW'(i_job.vc.x);
                    r_a[1] <= DiffW'(i_job.cur.y) - DiffW'(i_job.vc.y);
                    r_a[2] <= DiffW'(i_job.cur.z) - DiffW'(i_job.vc.z);
                    r_b[0] <= DiffW'(i_job.vu.x) - DiffW'(i_job.vc.x);
                    r_b[1] <= DiffW'(i_job.vu.y) - DiffW'(i_job.vc.y);
                    r_b[2] <= DiffW'(i_job.vu.z) - DiffW'(i_job.vc.z);
                    r_row  <= i_job.row;
                    r_col  <= i_job.col;
                end
            end
            ST_MUL: begin
                r_prod <= mul_p;
                case (r_step)
                    StepW'(1): r_c[0] <= CrossW'(r_prod);
                    StepW'(2): r_c[0] <= r_c[0] - CrossW'(r_prod);
                    StepW'(3): r_c[1] <= CrossW'(r_prod);
                    StepW'(4): r_c[1] <= r_c[1] - CrossW'(r_prod);
                    StepW'(5): r_c[2] <= CrossW'(r_prod);
                    StepW'(6): r_c[2] <= r_c[2] - CrossW'(r_prod);
                    default: ;
                endcase
            end
            ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_s[i] <= mag[i];
                end
                r_m <= mag_max;
            end
            ST_NORM: begin
                // one bit per cycle until max lands in [2^23, 2^24)
                if (r_m[MagW-1:NormW] != '0) begin
                    r_m <= r_m >> 1;
                    for (int i = 0; i < 3; i++) r_s[i] <= r_s[i] >> 1;
                end else if (!r_m[NormW-1] && !degen) begin
                    r_m <= r_m << 1;
                    for (int i = 0; i < 3; i++) r_s[i] <= r_s[i] << 1;
                end
            end
            ST_SQR: begin
                r_prod <= mul_p;
                case (r_step)
                    StepW'(1): r_sum <= SumW'(r_prod);
                    StepW'(2): r_sum <= sum_fin;
                    StepW'(3): begin
                        r_x   <= RootW'(sum_fin) << SqrShift;
                        r_res <= '0;
                        r_bit <= RootW'(1) << (RootW - 2);
                    end
                    default: ;
                endcase
            end
            ST_ROOT: begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_DIV: begin
                if (r_step == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_rem[i] <= (NumW'(r_s[i][NormW-1:0]) << NumShift) + NumW'(root);
                        r_q[i]   <= '0;
                    end
                    r_den <= NumW'(root) << DivSteps;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_rem[i] >= r_den) begin
                            r_rem[i] <= r_rem[i] - r_den;
                            r_q[i]   <= {r_q[i][QW-2:0], 1'b1};
                        end else begin
                            r_q[i]   <= {r_q[i][QW-2:0], 1'b0};
                        end
                    end
                    r_den <= r_den >> 1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out <= '{nx: comp[0], ny: comp[1], nz: comp[2],
                               row: r_row, col: r_col, degen: degen};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/grid_surface_normals.sv =====
// Grid surface normals.
// i_vertex: one beat per grid vertex in raster order (rows outer, columns
// inner); grid_start on a beat makes it vertex (0,0) of a new grid.
// o_normal: one beat for each vertex (u+1,v) with v before the last column,
// carrying the unit normal of cell (u,v) in Q1.14, the cell index and a
// degenerate flag (components zero) when the cross product is zero.
// i_cfg_we/i_cfg_wdata: vertices per row, clamped to [2, MAX_COLUMNS];
// write only while the block is idle.
// The back end takes one job at a time, only from idle, and works it
// through its steps in order: six cross terms and three squares on one
// shared multiplier, a 1-bit/cycle normalizing shift, a 32-step square
// root and a 15-step divider on three lanes at once; a degenerate cell
// goes from the normalizing shift straight to the output.
// Beats that give no normal pass the front without waiting on the back end.
// The front (line buffer, counters) keeps taking beats while the back works
// until the two-entry queue fills; a stalled receiver holds the output
// register, then the back end, then the queue, then i_vertex.ready.
// Reset clears counters, queue and the column register (4096); the line
// buffer is not cleared and needs no time after reset.
module grid_surface_normals #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    gsn_vertex_if.sink                i_vertex,
    gsn_normal_if.source              o_normal,
    input  logic                      i_cfg_we,
    input  logic [gsn_pkg::CfgW-1:0]  i_cfg_wdata
);
    import gsn_pkg::*;

    logic [CfgW-1:0] r_grid_columns;
    t_vec            vertex;
    logic            front_valid;
    logic            front_ready;
    t_job            front_job;
    logic            back_valid;
    logic            back_ready;
    t_job            back_job;
    t_result         result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= CfgW'(4096);
        end else if (i_cfg_we) begin
            r_grid_columns <= i_cfg_wdata;
        end
    end

    assign vertex = '{x: i_vertex.vertex_x, y: i_vertex.vertex_y, z: i_vertex.vertex_z};

    gsn_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grid_columns (r_grid_columns),
        .i_valid        (i_vertex.valid),
        .o_ready        (i_vertex.ready),
        .i_vertex       (vertex),
        .i_grid_start   (i_vertex.grid_start),
        .o_job_valid    (front_valid),
        .i_job_ready    (front_ready),
        .o_job          (front_job)
    );

    gsn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_job    (back_job)
    );

    gsn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .i_job       (back_job),
        .o_valid     (o_normal.valid),
        .i_ready     (o_normal.ready),
        .o_result    (result)
    );

    assign o_normal.normal_x   = result.nx;
    assign o_normal.normal_y   = result.ny;
    assign o_normal.normal_z   = result.nz;
    assign o_normal.cell_row   = result.row;
    assign o_normal.cell_col   = result.col;
    assign o_normal.degenerate = result.degen;

    // degenerate beats carry a zero vector
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_normal.valid && o_normal.degenerate |->
            (o_normal.normal_x == '0) && (o_normal.normal_y == '0) &&
            (o_normal.normal_z == '0))
        else $error("degenerate normal with nonzero component");

    // a unit normal never comes out as the zero vector
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_normal.valid && !o_normal.degenerate |->
            (o_normal.normal_x != '0) || (o_normal.normal_y != '0) ||
            (o_normal.normal_z != '0))
        else $error("zero normal without degenerate flag");

    // components stay within +-1.0
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_normal.valid |->
            (o_normal.normal_x <= 16'sd16384) && (o_normal.normal_x >= -16'sd16384) &&
            (o_normal.normal_y <= 16'sd16384) && (o_normal.normal_y >= -16'sd16384) &&
            (o_normal.normal_z <= 16'sd16384) && (o_normal.normal_z >= -16'sd16384))
        else $error("normal component out of range");

endmodule
